FILE: rtl/core/pwmm_pkg.sv
// Shared constants and types for the PWM input period and duty meter.
// No dependencies.
`default_nettype none

package pwmm_pkg;

    localparam int TW = 32;              // timestamp and tick count width
    localparam int FW = 16;              // duty fraction bits
    localparam int NW = TW + FW;         // divider dividend width
    localparam int CW = $clog2(NW + 1);  // bit counter width
    localparam int OW = 32;              // tick and frequency field width
    localparam int DW = FW + 1;          // duty field width

    localparam logic [OW-1:0] RELOAD_RST = OW'(83999999);

    typedef logic [TW-1:0] t_time;
    typedef logic [TW:0]   t_period;
    typedef logic [DW-1:0] t_duty;

endpackage

`default_nettype wire

FILE: rtl/core/pwmm_if.sv
// Valid/ready channels of the PWM meter: capture events in, results out.
// Depends on pwmm_pkg.
`default_nettype none

interface pwmm_cap_if import pwmm_pkg::*; ();
    logic          valid;
    logic          ready;
    logic          edge_level;
    logic [OW-1:0] capture_time;

    modport source (output valid, edge_level, capture_time, input ready);
    modport sink   (input valid, edge_level, capture_time, output ready);
endinterface

interface pwmm_res_if import pwmm_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [OW-1:0] low_ticks;
    logic [OW-1:0] high_ticks;
    t_duty         high_duty;
    t_duty         low_duty;
    logic [OW-1:0] frequency;

    modport source (output valid, low_ticks, high_ticks, high_duty, low_duty, frequency,
                    input ready);
    modport sink   (input valid, low_ticks, high_ticks, high_duty, low_duty, frequency,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pwm_input_period_duty_meter.sv
// PWM input period and duty meter: top level, bit-serial elapsed time and a
// shared radix-2 divider. Depends on pwmm_pkg and pwmm_if.
//
//  channel  dir  handshake          beat
//  i_cap    in   valid/ready        edge_level, capture_time
//  o_res    out  valid/ready        low_ticks, high_ticks, high_duty, low_duty, frequency
//  i_cfg    in   i_cfg_wr_en        i_cfg_wr_data -> counter_reload
//
// Falling edge: bit-serial elapsed time, one bit per cycle.
// Rising edge: the same elapsed time, then three divider passes (high duty, low duty,
// frequency); a zero period skips the divider. One beat in flight; the output register
// holds a result while the next beat is taken and worked on.
// Reset is synchronous; it clears the stored edge times and the held high time.
`default_nettype none

module pwm_input_period_duty_meter import pwmm_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [OW-1:0] i_cfg_wr_data,
    pwmm_cap_if.sink           i_cap,
    pwmm_res_if.source         o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ELAP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [1:0] P_HDUTY = 2'd0;
    localparam logic [1:0] P_LDUTY = 2'd1;
    localparam logic [1:0] P_FREQ  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_pass, n_pass;
    logic          r_ovalid, n_ovalid;
    logic [OW-1:0] r_reload, n_reload;
    t_time         r_last_rise, n_last_rise;
    t_time         r_last_fall, n_last_fall;
    t_time         r_held_high, n_held_high;

    logic          r_level, n_level;
    t_time         r_sh_a, n_sh_a;
    t_time         r_sh_b, n_sh_b;
    t_time         r_sh_c, n_sh_c;
    logic          r_borrow, n_borrow;
    logic          r_carry, n_carry;
    logic          r_nz, n_nz;
    t_time         r_low, n_low;
    t_time         r_high, n_high;
    t_period       r_period, n_period;
    logic [NW-1:0] r_dvd, n_dvd;
    t_period       r_rem, n_rem;
    t_duty         r_hduty, n_hduty;
    t_duty         r_lduty, n_lduty;
    logic [OW-1:0] r_freq, n_freq;
    logic [OW-1:0] r_o_low, n_o_low;
    logic [OW-1:0] r_o_high, n_o_high;
    t_duty         r_o_hduty, n_o_hduty;
    t_duty         r_o_lduty, n_o_lduty;
    logic [OW-1:0] r_o_freq, n_o_freq;

    logic          bit_a, bit_b, bit_c, bit_d, bit_s;
    logic          gt;
    t_time         elap;
    t_period       per;
    t_period       modulus;
    logic [TW+1:0] trial, trial_sub;
    logic          ge;
    logic [63:0]   q_ext;

    assign i_cap.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_ovalid;
    assign o_res.low_ticks  = r_o_low;
    assign o_res.high_ticks = r_o_high;
    assign o_res.high_duty  = r_o_hduty;
    assign o_res.low_duty   = r_o_lduty;
    assign o_res.frequency  = r_o_freq;

    assign bit_a = r_sh_a[0];
    assign bit_b = r_sh_b[0];
    assign bit_c = r_sh_c[0];
    assign bit_d = bit_a ^ bit_b ^ r_borrow;
    assign bit_s = bit_d ^ bit_c ^ r_carry;

    assign gt      = ~r_borrow & r_nz;
    assign elap    = gt ? r_sh_a : r_sh_b;
    assign per     = {1'b0, elap} + {1'b0, r_held_high};
    assign modulus = {1'b0, r_reload[TW-1:0]} + t_period'(1);

    assign trial     = {r_rem, r_dvd[NW-1]};
    assign trial_sub = trial - {1'b0, r_period};
    assign ge        = (trial >= {1'b0, r_period});
    assign q_ext     = 64'(r_dvd);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_ovalid    = r_ovalid;
        n_reload    = r_reload;
        n_last_rise = r_last_rise;
        n_last_fall = r_last_fall;
        n_held_high = r_held_high;
        n_level     = r_level;
        n_sh_a      = r_sh_a;
        n_sh_b      = r_sh_b;
        n_sh_c      = r_sh_c;
        n_borrow    = r_borrow;
        n_carry     = r_carry;
        n_nz        = r_nz;
        n_low       = r_low;
        n_high      = r_high;
        n_period    = r_period;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_hduty     = r_hduty;
        n_lduty     = r_lduty;
        n_freq      = r_freq;
        n_o_low     = r_o_low;
        n_o_high    = r_o_high;
        n_o_hduty   = r_o_hduty;
        n_o_lduty   = r_o_lduty;
        n_o_freq    = r_o_freq;

        if (i_cfg_wr_en) begin
            n_reload = i_cfg_wr_data;
        end
        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cap.valid) begin
                    n_level  = i_cap.edge_level;
                    n_sh_a   = i_cap.capture_time[TW-1:0];
                    n_sh_c   = r_reload[TW-1:0];
                    n_borrow = 1'b0;
                    n_carry  = 1'b1;
                    n_nz     = 1'b0;
                    n_cnt    = CW'(TW);
                    n_state  = S_ELAP;
                    if (i_cap.edge_level) begin
                        n_sh_b      = r_last_fall;
                        n_last_rise = i_cap.capture_time[TW-1:0];
                    end else begin
                        n_sh_b      = r_last_rise;
                        n_last_fall = i_cap.capture_time[TW-1:0];
                    end
                end
            end
            S_ELAP: begin
                if (r_cnt != '0) begin
                    // diff = now - then; alt = diff + reload + 1
                    n_sh_a   = {bit_d, r_sh_a[TW-1:1]};
                    n_sh_b   = {bit_s, r_sh_b[TW-1:1]};
                    n_sh_c   = {1'b0, r_sh_c[TW-1:1]};
                    n_borrow = (~bit_a & bit_b) | (~(bit_a ^ bit_b) & r_borrow);
                    n_carry  = (bit_d & bit_c) | (r_carry & (bit_d ^ bit_c));
                    n_nz     = r_nz | bit_d;
                    n_cnt    = r_cnt - CW'(1);
                end else if (!r_level) begin
                    n_held_high = elap;
                    n_state     = S_IDLE;
                end else begin
                    n_low    = elap;
                    n_high   = r_held_high;
                    n_period = per;
                    if (per == '0) begin
                        n_hduty = '0;
                        n_lduty = '0;
                        n_freq  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_dvd   = {r_held_high, {FW{1'b0}}};
                        n_rem   = '0;
                        n_cnt   = CW'(NW);
                        n_pass  = P_HDUTY;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = ge ? trial_sub[TW:0] : trial[TW:0];
                    n_dvd = {r_dvd[NW-2:0], ge};
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    n_rem = '0;
                    n_cnt = CW'(NW);
                    case (r_pass)
                        P_HDUTY: begin
                            n_hduty = r_dvd[DW-1:0];
                            n_dvd   = {r_low, {FW{1'b0}}};
                            n_pass  = P_LDUTY;
                        end
                        P_LDUTY: begin
                            n_lduty = r_dvd[DW-1:0];
                            n_dvd   = NW'(modulus);
                            n_pass  = P_FREQ;
                        end
                        P_FREQ: begin
                            n_freq  = (|q_ext[63:OW]) ? '1 : q_ext[OW-1:0];
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid  = 1'b1;
                    n_o_low   = OW'(r_low);
                    n_o_high  = OW'(r_high);
                    n_o_hduty = r_hduty;
                    n_o_lduty = r_lduty;
                    n_o_freq  = r_freq;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pass      <= P_HDUTY;
            r_ovalid    <= 1'b0;
            r_reload    <= RELOAD_RST;
            r_last_rise <= '0;
            r_last_fall <= '0;
            r_held_high <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_ovalid    <= n_ovalid;
            r_reload    <= n_reload;
            r_last_rise <= n_last_rise;
            r_last_fall <= n_last_fall;
            r_held_high <= n_held_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level   <= n_level;
        r_sh_a    <= n_sh_a;
        r_sh_b    <= n_sh_b;
        r_sh_c    <= n_sh_c;
        r_borrow  <= n_borrow;
        r_carry   <= n_carry;
        r_nz      <= n_nz;
        r_low     <= n_low;
        r_high    <= n_high;
        r_period  <= n_period;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_hduty   <= n_hduty;
        r_lduty   <= n_lduty;
        r_freq    <= n_freq;
        r_o_low   <= n_o_low;
        r_o_high  <= n_o_high;
        r_o_hduty <= n_o_hduty;
        r_o_lduty <= n_o_lduty;
        r_o_freq  <= n_o_freq;
    end

endmodule

`default_nettype wire
